[src/ccs_pkg.sv]
// ============================================================================
// ccs_pkg
// Shared constants and types for the Chaikin corner-cutting block.
// ============================================================================
package ccs_pkg;

  // Default coordinate width (signed Q16.16)
  localparam int CoordWidth = 32;

  // Number of coordinates per point
  localparam int NumAxes = 3;

  // Depth of the command queue between front and back
  localparam int QueueDepth = 2;

  // Points seen in the current curve saturate at this count
  localparam logic [1:0] SeenNone = 2'd0;
  localparam logic [1:0] SeenOne  = 2'd1;
  localparam logic [1:0] SeenSat  = 2'd2;

  // Blend shift amounts
  localparam logic [1:0] ShiftHalf    = 2'd1;
  localparam logic [1:0] ShiftQuarter = 2'd2;

  // Result steps inside one command
  localparam logic [1:0] StepFirst  = 2'd0;
  localparam logic [1:0] StepSecond = 2'd1;
  localparam logic [1:0] StepThird  = 2'd2;

  // Command kinds issued by the front for each accepted point
  typedef enum logic [2:0] {
    KIND_PASS      = 3'd0,  // first point: point itself
    KIND_PASS_LAST = 3'd1,  // lone point: point itself, marked last
    KIND_MID       = 3'd2,  // second point: midpoint
    KIND_MID_TWICE = 3'd3,  // second point, last: midpoint, midpoint, point
    KIND_MID_END   = 3'd4,  // later last point: midpoint, point
    KIND_QUARTER   = 3'd5   // later point: 3/4-1/4 and 1/4-3/4 blends
  } ccs_kind_e;

  localparam int KindWidth = $bits(ccs_kind_e);

endpackage

[src/ccs_in_if.sv]
// ============================================================================
// ccs_in_if
// Input channel: control point beats with end-of-curve flag.
// ============================================================================
interface ccs_in_if #(
  parameter int W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic signed [W-1:0] point_z;
  logic                end_of_curve;

  modport source (output valid, point_x, point_y, point_z, end_of_curve, input ready);
  modport sink   (input valid, point_x, point_y, point_z, end_of_curve, output ready);
endinterface

[src/ccs_out_if.sv]
// ============================================================================
// ccs_out_if
// Result channel: refined point beats with last flag.
// ============================================================================
interface ccs_out_if #(
  parameter int W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_x;
  logic signed [W-1:0] out_y;
  logic signed [W-1:0] out_z;
  logic                out_last;

  modport source (output valid, out_x, out_y, out_z, out_last, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_last, output ready);
endinterface

[src/ccs_front.sv]
// ============================================================================
// ccs_front
// Accepts control points, tracks curve position and issues one command per
// point (kind, previous point, current point) into the command queue.
// ============================================================================
module ccs_front
  import ccs_pkg::*;
#(
  parameter int COORD_WIDTH = CoordWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  ccs_in_if.sink                              pnt_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output ccs_kind_e                           kind_o,
  output logic [NumAxes-1:0][COORD_WIDTH-1:0] prev_o,
  output logic [NumAxes-1:0][COORD_WIDTH-1:0] cur_o
);

  logic [NumAxes-1:0][COORD_WIDTH-1:0] prev_q, prev_d;
  logic [1:0]                          seen_q, seen_d;
  logic                                accept;
  logic                                last;

  assign accept       = pnt_i.valid & push_ready_i;
  assign last         = pnt_i.end_of_curve;
  assign pnt_i.ready  = push_ready_i;
  assign push_valid_o = pnt_i.valid;

  assign cur_o[0] = pnt_i.point_x;
  assign cur_o[1] = pnt_i.point_y;
  assign cur_o[2] = pnt_i.point_z;
  assign prev_o   = prev_q;

  // Classify the point by its place in the curve
  always_comb begin
    case (seen_q)
      SeenNone: kind_o = last ? KIND_PASS_LAST : KIND_PASS;
      SeenOne:  kind_o = last ? KIND_MID_TWICE : KIND_MID;
      default:  kind_o = last ? KIND_MID_END   : KIND_QUARTER;
    endcase
  end

  // Curve position and previous point
  always_comb begin
    prev_d = prev_q;
    seen_d = seen_q;
    if (accept) begin
      prev_d = cur_o;
      if (last) begin
        seen_d = SeenNone;
      end else if (seen_q != SeenSat) begin
        seen_d = seen_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      seen_q <= SeenNone;
    end else begin
      prev_q <= prev_d;
      seen_q <= seen_d;
    end
  end

endmodule

[src/ccs_queue.sv]
// ============================================================================
// ccs_queue
// Short command queue that decouples the front from the back.
// ============================================================================
module ccs_queue
  import ccs_pkg::*;
#(
  parameter int DATA_W = KindWidth + 2 * NumAxes * CoordWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  logic [DATA_W-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/ccs_back.sv]
// ============================================================================
// ccs_back
// Pops commands and emits their refined points through an output register,
// one beat per cycle while the output is ready; blends are shift-and-add with arithmetic floor.
// ============================================================================
module ccs_back
  import ccs_pkg::*;
#(
  parameter int COORD_WIDTH = CoordWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                pop_valid_i,
  output logic                                pop_ready_o,
  input  ccs_kind_e                           kind_i,
  input  logic [NumAxes-1:0][COORD_WIDTH-1:0] prev_i,
  input  logic [NumAxes-1:0][COORD_WIDTH-1:0] cur_i,
  ccs_out_if.source                           res_o
);

  // a + floor((b - a) / 2^s)
  function automatic logic [COORD_WIDTH-1:0] blend(
    input logic [COORD_WIDTH-1:0] a,
    input logic [COORD_WIDTH-1:0] b,
    input logic [1:0]             s
  );
    logic signed [COORD_WIDTH:0] diff;
    logic signed [COORD_WIDTH:0] sum;
    diff  = $signed({b[COORD_WIDTH-1], b}) - $signed({a[COORD_WIDTH-1], a});
    diff  = diff >>> s;
    sum   = $signed({a[COORD_WIDTH-1], a}) + diff;
    return sum[COORD_WIDTH-1:0];
  endfunction

  // Command held while its beats go out
  ccs_kind_e                           kind_q, kind_d;
  logic [NumAxes-1:0][COORD_WIDTH-1:0] prev_q, prev_d;
  logic [NumAxes-1:0][COORD_WIDTH-1:0] cur_q, cur_d;
  logic                                busy_q, busy_d;
  logic [1:0]                          step_q, step_d;

  // Output register
  logic                                out_valid_q, out_valid_d;
  logic [NumAxes-1:0][COORD_WIDTH-1:0] out_pt_q, out_pt_d;
  logic                                out_last_q, out_last_d;

  logic                                advance;
  logic                                final_step;
  logic                                use_cur;
  logic                                swap;
  logic [1:0]                          shift;
  logic                                beat_last;
  logic                                load;
  logic [NumAxes-1:0][COORD_WIDTH-1:0] beat_pt;

  assign advance = !out_valid_q || res_o.ready;

  // Per-kind step decode
  always_comb begin
    final_step = 1'b1;
    use_cur    = 1'b0;
    swap       = 1'b0;
    shift      = ShiftHalf;
    beat_last  = 1'b0;
    case (kind_q)
      KIND_PASS: begin
        use_cur = 1'b1;
      end
      KIND_PASS_LAST: begin
        use_cur   = 1'b1;
        beat_last = 1'b1;
      end
      KIND_MID: begin
        final_step = 1'b1;
      end
      KIND_MID_TWICE: begin
        final_step = (step_q == StepThird);
        use_cur    = final_step;
        beat_last  = final_step;
      end
      KIND_MID_END: begin
        final_step = (step_q == StepSecond);
        use_cur    = final_step;
        beat_last  = final_step;
      end
      KIND_QUARTER: begin
        final_step = (step_q == StepSecond);
        swap       = final_step;
        shift      = ShiftQuarter;
      end
      default: begin
        final_step = 1'b1;
      end
    endcase
  end

  // One blend unit per axis
  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      if (use_cur) begin
        beat_pt[i] = cur_q[i];
      end else if (swap) begin
        beat_pt[i] = blend(cur_q[i], prev_q[i], shift);
      end else begin
        beat_pt[i] = blend(prev_q[i], cur_q[i], shift);
      end
    end
  end

  // Sequencer: take the next command once the current one is done
  assign load        = !busy_q || (advance && final_step);
  assign pop_ready_o = load;

  always_comb begin
    kind_d = kind_q;
    prev_d = prev_q;
    cur_d  = cur_q;
    busy_d = busy_q;
    step_d = step_q;
    if (load) begin
      busy_d = pop_valid_i;
      step_d = StepFirst;
      kind_d = kind_i;
      prev_d = prev_i;
      cur_d  = cur_i;
    end else if (advance) begin
      step_d = step_q + 2'd1;
    end
  end

  // Output register load
  always_comb begin
    out_valid_d = out_valid_q;
    out_pt_d    = out_pt_q;
    out_last_d  = out_last_q;
    if (advance) begin
      out_valid_d = busy_q;
      out_pt_d    = beat_pt;
      out_last_d  = beat_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= StepFirst;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    out_pt_q   <= out_pt_d;
    out_last_q <= out_last_d;
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.out_x    = out_pt_q[0];
  assign res_o.out_y    = out_pt_q[1];
  assign res_o.out_z    = out_pt_q[2];
  assign res_o.out_last = out_last_q;

endmodule

[src/chaikin_curve_subdivision_top.sv]
// ============================================================================
// chaikin_curve_subdivision_top
// One pass of open-curve Chaikin corner cutting on a stream of 3D points.
// ============================================================================
//
//   port    | dir | payload                                | beat
//   --------+-----+----------------------------------------+--------------------
//   pnt_i   | in  | point_x/y/z (signed), end_of_curve     | one control point
//   res_o   | out | out_x/y/z (signed), out_last           | one refined point
//
// The back emits one beat per cycle while the output is ready: a first or second
// point yields one refined point, an interior or last point two, and the last of a
// two-point curve three; the output beat rate of the back sets the throughput.
// An accepted point passes the queue, the command register and the output register.
// A two-entry command queue lets the input keep accepting while results stall, until it is full.
// Reset is asynchronous and active low; no clearing pass is needed.
// ============================================================================
module chaikin_curve_subdivision_top
  import ccs_pkg::*;
#(
  parameter int COORD_WIDTH = CoordWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ccs_in_if.sink    pnt_i,
  ccs_out_if.source res_o
);

  localparam int PtW   = NumAxes * COORD_WIDTH;
  localparam int EntryW = KindWidth + 2 * PtW;

  logic                                push_valid, push_ready;
  logic                                pop_valid, pop_ready;
  ccs_kind_e                           push_kind;
  logic [NumAxes-1:0][COORD_WIDTH-1:0] push_prev, push_cur;
  logic [NumAxes-1:0][COORD_WIDTH-1:0] pop_prev, pop_cur;
  logic [EntryW-1:0]                   push_data, pop_data;
  ccs_kind_e                           pop_kind;

  ccs_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pnt_i        (pnt_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .kind_o       (push_kind),
    .prev_o       (push_prev),
    .cur_o        (push_cur)
  );

  assign push_data = {push_kind, push_prev, push_cur};

  ccs_queue #(
    .DATA_W (EntryW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign pop_kind = ccs_kind_e'(pop_data[EntryW-1 -: KindWidth]);
  assign pop_prev = pop_data[2*PtW-1 -: PtW];
  assign pop_cur  = pop_data[PtW-1:0];

  ccs_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .kind_i      (pop_kind),
    .prev_i      (pop_prev),
    .cur_i       (pop_cur),
    .res_o       (res_o)
  );

endmodule

[tb/chaikin_curve_subdivision_top_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// chaikin_curve_subdivision_top_tb
// Self-checking bench for one pass of streamed Chaikin corner cutting.
// A queue of control points feeds a clocked driver, and a clocked monitor
// takes the refined points. Each accepted point runs through a corner-cutting
// predictor, and each refined point is checked against the oldest prediction.
// Both sides idle at random. The receiver also holds off for long stretches,
// and the sender pauses at times until every predicted point has come out.
// ============================================================================
module chaikin_curve_subdivision_top_tb
  import ccs_pkg::*;
();

  localparam int IdleLimit  = 2000;  // cycles with no beat on either side
  localparam int TailCycles = 20;
  localparam int LongHold   = 80;
  localparam int NumPoints  = 170;

  typedef logic signed [CoordWidth-1:0] coord_t;

  localparam coord_t MaxC = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam coord_t MinC = {1'b1, {(CoordWidth-1){1'b0}}};

  // control point plus a flag that holds it back until the output drains
  typedef struct {
    coord_t c [NumAxes];
    logic   last;
    logic   drain_first;
  } ctl_point_t;

  typedef struct {
    coord_t c [NumAxes];
    logic   last;
  } fine_point_t;

  logic clk_i;
  logic rst_ni;

  ccs_in_if  #(.W(CoordWidth)) pnt_if ();
  ccs_out_if #(.W(CoordWidth)) res_if ();

  chaikin_curve_subdivision_top #(.COORD_WIDTH(CoordWidth)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pnt_i  (pnt_if.sink),
    .res_o  (res_if.source)
  );

  ctl_point_t  pending_q [$];
  fine_point_t refined_q [$];

  // predictor state
  coord_t     prev_pt [NumAxes];
  logic [1:0] seen_cnt;

  int n_errors;
  int n_queued;
  int n_points_in;
  int n_points_out;
  int idle_cycles;

  ctl_point_t drv_pt;
  logic       drv_busy;
  int         drv_gap;
  int         rdy_gap;
  int         hold_cnt;

  string axis_name [NumAxes] = '{"x", "y", "z"};

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    n_errors++;
  endtask

  // a + floor((b - a) / 2^sh), kept one bit wider so the difference never wraps
  function automatic coord_t blend(input coord_t a, input coord_t b, input logic [1:0] sh);
    logic signed [CoordWidth:0] diff;
    diff = $signed({b[CoordWidth-1], b}) - $signed({a[CoordWidth-1], a});
    return coord_t'(a + (diff >>> sh));
  endfunction

  task automatic queue_refined(input coord_t c [NumAxes], input logic last);
    fine_point_t r;
    r.c       = c;
    r.last    = last;
    refined_q = {refined_q, r};
  endtask

  // predict the refined points caused by one accepted control point
  task automatic cut_corner(input ctl_point_t p);
    coord_t mid [NumAxes];
    coord_t near_prev [NumAxes];
    coord_t near_cur [NumAxes];
    for (int a = 0; a < NumAxes; a++) begin
      mid[a]       = blend(prev_pt[a], p.c[a], ShiftHalf);
      near_prev[a] = blend(prev_pt[a], p.c[a], ShiftQuarter);
      near_cur[a]  = blend(p.c[a], prev_pt[a], ShiftQuarter);
    end
    case (seen_cnt)
      SeenNone: begin
        queue_refined(p.c, p.last);
      end
      SeenOne: begin
        queue_refined(mid, 1'b0);
        // two-point curve: midpoint twice, then the end point
        if (p.last) begin
          queue_refined(mid, 1'b0);
          queue_refined(p.c, 1'b1);
        end
      end
      default: begin
        if (p.last) begin
          queue_refined(mid, 1'b0);
          queue_refined(p.c, 1'b1);
        end else begin
          queue_refined(near_prev, 1'b0);
          queue_refined(near_cur, 1'b0);
        end
      end
    endcase
    prev_pt = p.c;
    if (p.last) seen_cnt = SeenNone;
    else if (seen_cnt != SeenSat) seen_cnt = seen_cnt + 2'd1;
  endtask

  task automatic queue_point(input coord_t x, input coord_t y, input coord_t z,
                             input logic last, input logic drain_first);
    ctl_point_t p;
    p.c[0]        = x;
    p.c[1]        = y;
    p.c[2]        = z;
    p.last        = last;
    p.drain_first = drain_first;
    pending_q     = {pending_q, p};
    n_queued++;
  endtask

  // mix of full-range, Q16.16-sized, extreme and tiny coordinates
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 200 << 16)) - coord_t'(100 << 16);
      2: begin
        case ($urandom_range(0, 3))
          0:       return MaxC;
          1:       return MinC;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return coord_t'($urandom_range(0, 64)) - coord_t'(32);
    endcase
  endfunction

  // driver: offers queued points, predicts on every accepted beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pnt_if.valid <= 1'b0;
      drv_busy = 1'b0;
      drv_gap  = 0;
    end else begin
      if (pnt_if.valid && pnt_if.ready) begin
        cut_corner(drv_pt);
        n_points_in++;
        drv_busy = 1'b0;
        drv_gap  = ((n_points_in / 24) % 4 == 3) ? 0 : $urandom_range(0, 5);
      end
      if (!drv_busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].drain_first && refined_q.size() != 0)) begin
          drv_pt   = pending_q.pop_front();
          drv_busy = 1'b1;
        end
      end
      pnt_if.valid <= drv_busy;
      if (drv_busy) begin
        pnt_if.point_x      <= drv_pt.c[0];
        pnt_if.point_y      <= drv_pt.c[1];
        pnt_if.point_z      <= drv_pt.c[2];
        pnt_if.end_of_curve <= drv_pt.last;
      end
    end
  end

  // monitor: checks refined beats, draws stalls and long hold-offs
  always @(posedge clk_i) begin
    fine_point_t got;
    fine_point_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      rdy_gap  = 0;
      hold_cnt = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got.c[0] = res_if.out_x;
        got.c[1] = res_if.out_y;
        got.c[2] = res_if.out_z;
        got.last = res_if.out_last;
        if (refined_q.size() == 0) begin
          flag_error($sformatf("unexpected point (%0d, %0d, %0d) last=%b",
                               got.c[0], got.c[1], got.c[2], got.last));
        end else begin
          want = refined_q.pop_front();
          for (int a = 0; a < NumAxes; a++)
            if (got.c[a] !== want.c[a])
              flag_error($sformatf("point %0d: %s is %0d, want %0d",
                                   n_points_out, axis_name[a], got.c[a], want.c[a]));
          if (got.last !== want.last)
            flag_error($sformatf("point %0d: last is %b, want %b",
                                 n_points_out, got.last, want.last));
        end
        n_points_out++;
        rdy_gap = ((n_points_out / 40) % 4 == 2) ? 0 : $urandom_range(0, 5);
        if (n_points_out == 60 || n_points_out == 180) hold_cnt = LongHold;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_if.ready <= 1'b0;
      end else if (rdy_gap > 0) begin
        rdy_gap--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pnt_if.valid && pnt_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("chaikin_curve_subdivision_top test failed");
        $finish;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int len;
    pnt_if.valid        = 1'b0;
    pnt_if.point_x      = '0;
    pnt_if.point_y      = '0;
    pnt_if.point_z      = '0;
    pnt_if.end_of_curve = 1'b0;
    res_if.ready        = 1'b0;
    rst_ni              = 1'b0;
    drv_busy            = 1'b0;
    seen_cnt            = SeenNone;
    n_errors            = 0;
    n_queued            = 0;
    n_points_in         = 0;
    n_points_out        = 0;
    idle_cycles         = 0;
    for (int a = 0; a < NumAxes; a++) prev_pt[a] = '0;

    // lone point at the extremes
    queue_point(MaxC, MinC, 0, 1'b1, 1'b0);
    // two-point curve across the full range
    queue_point(MinC, MaxC, -1, 1'b0, 1'b0);
    queue_point(MaxC, MinC, 1, 1'b1, 1'b0);
    // three-point curve: midpoints over full-range jumps
    queue_point(MaxC, MaxC, MinC, 1'b0, 1'b0);
    queue_point(MinC, MinC, MaxC, 1'b0, 1'b0);
    queue_point(MaxC, 0, -1, 1'b1, 1'b0);
    // odd and negative differences exercise the floor rounding
    queue_point(0, 0, 0, 1'b0, 1'b0);
    queue_point(-1, 1, -3, 1'b0, 1'b0);
    queue_point(5, -5, 7, 1'b0, 1'b0);
    queue_point(-7, 2, -1, 1'b0, 1'b0);
    queue_point(3, -3, -2, 1'b0, 1'b0);
    queue_point(1, 1, 1, 1'b1, 1'b0);
    // back-to-back lone points
    queue_point(MinC, -1, MaxC, 1'b1, 1'b0);
    queue_point(-1, MaxC, MinC, 1'b1, 1'b0);
    // Q16.16 fractions in a short curve
    queue_point(32'sh0001_8000, -32'sh0002_4000, 32'sh7fff_0000, 1'b0, 1'b0);
    queue_point(-32'sh0000_0001, 32'sh0000_c000, -32'sh0001_0001, 1'b1, 1'b0);

    // random curves, mostly short; the first, and others at random, wait for the output to drain
    while (n_queued < NumPoints) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++)
        queue_point(rand_coord(), rand_coord(), rand_coord(), k == len - 1,
                    k == 0 && (n_queued == 16 || $urandom_range(0, 15) == 0));
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    wait (pending_q.size() == 0 && !drv_busy);
    wait (refined_q.size() == 0);
    repeat (TailCycles) @(posedge clk_i);

    if (n_errors == 0)
      $display("chaikin_curve_subdivision_top test passed");
    else
      $display("chaikin_curve_subdivision_top test failed");
    $finish;
  end

endmodule

[filelist.f]
src/ccs_pkg.sv
src/ccs_in_if.sv
src/ccs_out_if.sv
src/ccs_front.sv
src/ccs_queue.sv
src/ccs_back.sv
src/chaikin_curve_subdivision_top.sv
tb/chaikin_curve_subdivision_top_tb.sv
